// ----- hw/rtl/pbd_pkg.sv -----
package pbd_pkg;

  // sample and field widths
  localparam int SMP_W      = 10;
  localparam int TIME_W     = 32;
  localparam int SPER_W     = 10;
  localparam int UPER_W     = 16;
  localparam int MINT_W     = 13;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = SMP_W + FRAC_W;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FRACTION  = CFG_IDX_W'(3);

  // reset values
  localparam logic [SPER_W-1:0] SAMPLE_PERIOD_RST = SPER_W'(20);
  localparam logic [UPER_W-1:0] UPDATE_PERIOD_RST = UPER_W'(1000);
  localparam logic [MINT_W-1:0] MIN_INTERVAL_RST  = MINT_W'(300);
  localparam logic [FRAC_W-1:0] THR_FRACTION_RST  = FRAC_W'(39322);
  localparam logic [SMP_W-1:0]  LEVEL_RST         = SMP_W'(512);

  localparam int SAMPLE_DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK,
    ST_DRAIN,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } pbd_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic walk_rd;
    logic div_step;
    logic mul;
    logic add;
    logic finish;
  } pbd_cmd_t;

  typedef struct packed {
    logic acc;
    logic upd;
    logic walk_last;
  } pbd_sts_t;

endpackage

// ----- hw/rtl/pbd_channels.sv -----
interface pbd_in_if;
  logic                      valid;
  logic                      ready;
  logic [pbd_pkg::TIME_W-1:0] now_ms;
  logic [pbd_pkg::SMP_W-1:0]  raw_sample;

  modport source (output valid, output now_ms, output raw_sample, input ready);
  modport sink   (input valid, input now_ms, input raw_sample, output ready);
endinterface

interface pbd_out_if;
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic [pbd_pkg::SMP_W-1:0] average_level;
  logic [pbd_pkg::SMP_W-1:0] beat_threshold;
  logic                     in_peak;
  logic                     beat;

  modport source (output valid, output accepted, output average_level,
                  output beat_threshold, output in_peak, output beat, input ready);
  modport sink   (input valid, input accepted, input average_level,
                  input beat_threshold, input in_peak, input beat, output ready);
endinterface

interface pbd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pbd_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [pbd_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- hw/rtl/pbd_ctrl.sv -----
module pbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pbd_pkg::pbd_sts_t sts,
  output pbd_pkg::pbd_cmd_t cmd
);

  pbd_pkg::pbd_state_t state_r, state_nxt;
  logic                out_valid_r;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == pbd_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbd_pkg::ST_IDLE:  if (in_valid) state_nxt = pbd_pkg::ST_EVAL;
      pbd_pkg::ST_EVAL: begin
        if (sts.acc && sts.upd) state_nxt = pbd_pkg::ST_WALK;
        else                    state_nxt = pbd_pkg::ST_DONE;
      end
      pbd_pkg::ST_WALK:  if (sts.walk_last) state_nxt = pbd_pkg::ST_DRAIN;
      pbd_pkg::ST_DRAIN: state_nxt = pbd_pkg::ST_DIV;
      pbd_pkg::ST_DIV:   state_nxt = pbd_pkg::ST_MUL;
      pbd_pkg::ST_MUL:   state_nxt = pbd_pkg::ST_ADD;
      pbd_pkg::ST_ADD:   state_nxt = pbd_pkg::ST_DONE;
      pbd_pkg::ST_DONE:  if (out_free) state_nxt = pbd_pkg::ST_IDLE;
      default:           state_nxt = pbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      pbd_pkg::ST_IDLE: cmd.capture  = in_valid;
      pbd_pkg::ST_EVAL: cmd.eval     = 1'b1;
      pbd_pkg::ST_WALK: cmd.walk_rd  = 1'b1;
      pbd_pkg::ST_DIV:  cmd.div_step = 1'b1;
      pbd_pkg::ST_MUL:  cmd.mul      = 1'b1;
      pbd_pkg::ST_ADD:  cmd.add      = 1'b1;
      pbd_pkg::ST_DONE: cmd.finish   = out_free;
      default:          cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.finish)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/pbd_datapath.sv -----
module pbd_datapath #(
  parameter int SAMPLE_DEPTH = pbd_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input request payload
  input  logic [pbd_pkg::TIME_W-1:0]     now_ms,
  input  logic [pbd_pkg::SMP_W-1:0]      raw_sample,
  // config write
  input  logic                           cfg_we,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // result payload
  output logic                           res_accepted,
  output logic [pbd_pkg::SMP_W-1:0]      res_average,
  output logic [pbd_pkg::SMP_W-1:0]      res_threshold,
  output logic                           res_in_peak,
  output logic                           res_beat,
  input  pbd_pkg::pbd_cmd_t              cmd,
  output pbd_pkg::pbd_sts_t              sts
);

  localparam int AW    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int FW    = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W = pbd_pkg::SMP_W + AW;
  localparam int SW    = pbd_pkg::SMP_W;
  localparam int TW    = pbd_pkg::TIME_W;
  localparam logic [AW-1:0]    LAST_IDX = AW'(SAMPLE_DEPTH - 1);
  localparam logic [FW-1:0]    FULL_CNT = FW'(SAMPLE_DEPTH);
  // reciprocal of the depth: ceil(2^RS / depth) gives an exact quotient
  // for every sum below 2^SUM_W
  localparam int RS    = SUM_W + AW;
  localparam int RCP_W = SUM_W + 2;
  localparam int QP_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] DIV_RCP =
    RCP_W'(((64'd1 << RS) + 64'(SAMPLE_DEPTH) - 64'd1) / 64'(SAMPLE_DEPTH));

  // config registers
  logic [pbd_pkg::SPER_W-1:0] smp_period_r;
  logic [pbd_pkg::UPER_W-1:0] upd_period_r;
  logic [pbd_pkg::MINT_W-1:0] min_int_r;
  logic [pbd_pkg::FRAC_W-1:0] frac_r;

  // detector state
  logic [TW-1:0] last_smp_r, last_upd_r, last_beat_r;
  logic [AW-1:0] wp_r;
  logic [FW-1:0] fill_r;
  logic          peak_r;
  logic [SW-1:0] avg_r, thr_r;

  // current request
  logic [TW-1:0] now_r;
  logic [SW-1:0] sample_r;
  logic          acc_r;

  // walk / divide / multiply
  logic [SW-1:0]                  ring_mem [SAMPLE_DEPTH];
  logic [AW-1:0]                  walk_addr_r;
  logic [SW-1:0]                  rd_data_r;
  logic                           rd_vld_r, rd_pend_r;
  logic [SUM_W-1:0]               sum_r;
  logic [SW-1:0]                  max_r;
  logic [SW-1:0]                  q_r;
  logic [pbd_pkg::PROD_W-1:0]     prod_r;

  logic [SW-1:0]    rd_val;
  logic [QP_W-1:0]  q_prod;
  logic [SW-1:0]    span;
  logic             beat_c, peak_nxt;

  assign sts.acc       = (now_r - last_smp_r) >= TW'(smp_period_r);
  assign sts.upd       = (now_r - last_upd_r) >= TW'(upd_period_r);
  assign sts.walk_last = (walk_addr_r == LAST_IDX);

  assign rd_val  = rd_vld_r ? rd_data_r : '0;
  assign q_prod  = QP_W'(sum_r) * QP_W'(DIV_RCP);
  assign span    = (max_r > q_r) ? (max_r - q_r) : '0;

  // beat decision uses the threshold after any update of this request
  assign beat_c = (sample_r > thr_r) && !peak_r &&
                  ((now_r - last_beat_r) > TW'(min_int_r));

  always_comb begin
    peak_nxt = peak_r;
    if (acc_r) begin
      if (beat_c)                           peak_nxt = 1'b1;
      else if ((sample_r <= thr_r) && peak_r) peak_nxt = 1'b0;
    end
  end

  // ring memory; unwritten entries are masked to zero via fill count
  always_ff @(posedge clk) begin
    if (cmd.eval && sts.acc) ring_mem[wp_r] <= sample_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) rd_data_r <= ring_mem[walk_addr_r];
  end

  // config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_period_r <= pbd_pkg::SAMPLE_PERIOD_RST;
      upd_period_r <= pbd_pkg::UPDATE_PERIOD_RST;
      min_int_r    <= pbd_pkg::MIN_INTERVAL_RST;
      frac_r       <= pbd_pkg::THR_FRACTION_RST;
      last_smp_r   <= '0;
      last_upd_r   <= '0;
      last_beat_r  <= '0;
      wp_r         <= '0;
      fill_r       <= '0;
      peak_r       <= 1'b0;
      avg_r        <= pbd_pkg::LEVEL_RST;
      thr_r        <= pbd_pkg::LEVEL_RST;
      rd_pend_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pbd_pkg::CFG_SAMPLE_PERIOD: smp_period_r <= cfg_wdata[pbd_pkg::SPER_W-1:0];
          pbd_pkg::CFG_UPDATE_PERIOD: upd_period_r <= cfg_wdata[pbd_pkg::UPER_W-1:0];
          pbd_pkg::CFG_MIN_INTERVAL:  min_int_r    <= cfg_wdata[pbd_pkg::MINT_W-1:0];
          pbd_pkg::CFG_THR_FRACTION:  frac_r       <= cfg_wdata[pbd_pkg::FRAC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.eval && sts.acc) begin
        last_smp_r <= now_r;
        wp_r       <= (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
        if (fill_r != FULL_CNT) fill_r <= fill_r + 1'b1;
        if (sts.upd) last_upd_r <= now_r;
      end
      rd_pend_r <= cmd.walk_rd;
      if (cmd.mul) avg_r <= q_r;
      if (cmd.add) thr_r <= avg_r + prod_r[pbd_pkg::PROD_W-1:pbd_pkg::FRAC_W];
      if (cmd.finish) begin
        peak_r <= peak_nxt;
        if (acc_r && beat_c) last_beat_r <= now_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r    <= now_ms;
      sample_r <= raw_sample;
    end
    if (cmd.eval) begin
      acc_r       <= sts.acc;
      walk_addr_r <= '0;
      sum_r       <= '0;
      max_r       <= '0;
    end
    if (cmd.walk_rd) begin
      rd_vld_r <= (FW'(walk_addr_r) < fill_r);
      if (!sts.walk_last) walk_addr_r <= walk_addr_r + 1'b1;
    end
    if (rd_pend_r) begin
      sum_r <= sum_r + SUM_W'(rd_val);
      if (rd_val > max_r) max_r <= rd_val;
    end
    // average: sum times reciprocal of the depth
    if (cmd.div_step) q_r <= q_prod[RS +: SW];
    if (cmd.mul) prod_r <= pbd_pkg::PROD_W'(span) * pbd_pkg::PROD_W'(frac_r);
    if (cmd.finish) begin
      res_accepted  <= acc_r;
      res_average   <= avg_r;
      res_threshold <= thr_r;
      res_in_peak   <= peak_nxt;
      res_beat      <= acc_r && beat_c;
    end
  end

endmodule

// ----- hw/rtl/pulse_beat_detector_top.sv -----
// Flow: a request that triggers an update walks the whole ring, one read per
//   cycle, then divides, multiplies and adds before its result is registered;
//   any other request goes straight to the result register. One request is
//   handled at a time; the next is taken once the result register is loaded.
// Reset: rst_n synchronous, active low; config to defaults, levels to 512,
//   ring reads as zero through a fill count, so no clearing pass is needed.
module pulse_beat_detector_top #(
  parameter int SAMPLE_DEPTH = pbd_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  pbd_in_if.sink    in_chan,
  pbd_out_if.source out_chan,
  pbd_cfg_if.sink   cfg_chan
);

  // command/status between sequencer and datapath
  pbd_pkg::pbd_cmd_t cmd;
  pbd_pkg::pbd_sts_t sts;

  // config writes are always taken; the user must change registers only while idle, not enforced by the block
  assign cfg_chan.ready = 1'b1;

  // sequencer: one request at a time, IDLE -> EVAL -> (walk, drain, divide,
  // multiply, add, on update) -> DONE; the result register frees the input side
  pbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: timers, ring memory, sum/max walk, reciprocal divide,
  // threshold math, beat decision and the result register
  pbd_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .now_ms        (in_chan.now_ms),
    .raw_sample    (in_chan.raw_sample),
    .cfg_we        (cfg_chan.valid && cfg_chan.ready),
    .cfg_index     (cfg_chan.reg_index),
    .cfg_wdata     (cfg_chan.wdata),
    .res_accepted  (out_chan.accepted),
    .res_average   (out_chan.average_level),
    .res_threshold (out_chan.beat_threshold),
    .res_in_peak   (out_chan.in_peak),
    .res_beat      (out_chan.beat),
    .cmd           (cmd),
    .sts           (sts)
  );

`ifndef SYNTHESIS
  // an accepted request is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> cmd.eval)
    else $error("accepted request not evaluated");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_chan.valid && !out_chan.ready))
    else $error("result register overwritten");

  // loading a result raises out valid
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_chan.valid)
    else $error("result not presented");

  // sequencer issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");
`endif

endmodule

// ----- verif/pulse_beat_detector_top_tb.sv -----
module pulse_beat_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbd_pkg::*;

  localparam int DEPTH = SAMPLE_DEPTH_DEF;
  // Slowest request (one that triggers a ring walk) plus margin.
  localparam int SETTLE_CYCLES = DEPTH + 24;
  // Receiver hold-off, long enough to back the block up into its input.
  localparam int LONG_HOLD = 400;
  // Roughly 900 requests, plus hold-off and settles.
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES = 6;

  // One result of the detector.
  typedef struct packed {
    logic             accepted;
    logic [SMP_W-1:0] average_level;
    logic [SMP_W-1:0] beat_threshold;
    logic             in_peak;
    logic             beat;
  } beat_report_t;

  // Directed stimulus row. 'fixed' rows carry a hand-computed result;
  // 'reconfig' reprograms zero periods and full fraction before the row.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [SMP_W-1:0]  smp;
    logic              fixed;
    logic              reconfig;
    beat_report_t      rep;
  } stim_row_t;

  // Per-request tag handed from the driver to the monitor.
  typedef struct {
    bit           fixed;
    beat_report_t rep;
  } req_tag_t;

  // Register settings of one random phase; the last phase draws its own.
  typedef struct packed {
    logic [15:0] sper;
    logic [15:0] uper;
    logic [15:0] mint;
    logic [15:0] frac;
    logic [15:0] count;
  } phase_t;

  // Held reset levels, nothing accepted.
  localparam beat_report_t REJ_RST = '{1'b0, 10'd512, 10'd512, 1'b0, 1'b0};
  localparam beat_report_t NO_REP  = '0;

  // Default registers: sample period 20, update 1000, min interval 300.
  localparam stim_row_t DIRECTED_ROWS [20] = '{
    // too early after the zero reset timestamp: rejected, levels at 512
    '{32'd0,          10'd1023, 1'b1, 1'b0, REJ_RST},
    '{32'd19,         10'd0,    1'b1, 1'b0, REJ_RST},
    // first accepted sample: high, but the min interval since time 0 not met
    '{32'd20,         10'd1023, 1'b1, 1'b0, '{1'b1, 10'd512, 10'd512, 1'b0, 1'b0}},
    // one above threshold, 301 ms since last beat: beat starts
    '{32'd301,        10'd513,  1'b1, 1'b0, '{1'b1, 10'd512, 10'd512, 1'b1, 1'b1}},
    // still in peak, no new beat
    '{32'd321,        10'd1023, 1'b1, 1'b0, '{1'b1, 10'd512, 10'd512, 1'b1, 1'b0}},
    // at threshold: peak ends
    '{32'd341,        10'd512,  1'b1, 1'b0, '{1'b1, 10'd512, 10'd512, 1'b0, 1'b0}},
    // above threshold but inside min interval
    '{32'd361,        10'd600,  1'b1, 1'b0, '{1'b1, 10'd512, 10'd512, 1'b0, 1'b0}},
    // first level update, then a beat just over the new threshold
    '{32'd1000,       10'd0,    1'b0, 1'b0, NO_REP},
    '{32'd1020,       10'd637,  1'b0, 1'b0, NO_REP},
    '{32'd1039,       10'd700,  1'b0, 1'b0, NO_REP},
    // timestamp wrap
    '{32'hFFFF_FFFF,  10'd5,    1'b0, 1'b0, NO_REP},
    '{32'h0000_0013,  10'd1023, 1'b0, 1'b0, NO_REP},
    '{32'h0000_0014,  10'd1023, 1'b0, 1'b0, NO_REP},
    '{32'hAAAA_AAAA,  10'h2AA,  1'b0, 1'b0, NO_REP},
    '{32'h5555_5555,  10'h155,  1'b0, 1'b0, NO_REP},
    '{32'h8000_0000,  10'd1023, 1'b0, 1'b0, NO_REP},
    // zero periods: same timestamp accepted, every sample updates levels
    '{32'h8000_0000,  10'd1023, 1'b0, 1'b1, NO_REP},
    '{32'h8000_0000,  10'd0,    1'b0, 1'b0, NO_REP},
    '{32'h8000_0001,  10'd1023, 1'b0, 1'b0, NO_REP},
    '{32'h8000_0001,  10'd1,    1'b0, 1'b0, NO_REP}
  };

  localparam phase_t PHASES [NUM_PHASES] = '{
    '{16'd20,   16'd1000,  16'd300,  16'd39322, 16'd220}, // defaults
    '{16'd0,    16'd0,     16'd0,    16'hFFFF,  16'd90},  // zero periods, max fraction
    '{16'd1023, 16'hFFFF,  16'd8191, 16'd0,     16'd90},  // all-ones widths, zero fraction
    '{16'd1,    16'd1,     16'd5000, 16'd32768, 16'd110}, // unit periods
    '{16'd10,   16'd500,   16'd200,  16'd39322, 16'd180}, // long receiver hold-off here
    '{16'd0,    16'd0,     16'd0,    16'd0,     16'd180}  // random registers
  };

  logic clk;
  logic rst_n;

  pbd_in_if  in_if();
  pbd_out_if out_if();
  pbd_cfg_if cfg_if();

  pulse_beat_detector_top #(.SAMPLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Detector model state: sample ring, timestamps, peak flag, levels.
  // ---------------------------------------------------------------------
  logic [SMP_W-1:0]  ring_mem [DEPTH];
  int unsigned       ring_wr;
  logic [TIME_W-1:0] t_last_smp;
  logic [TIME_W-1:0] t_last_upd;
  logic [TIME_W-1:0] t_last_beat;
  logic              peak_on;
  logic [SMP_W-1:0]  avg_lvl;
  logic [SMP_W-1:0]  thr_lvl;

  logic [SPER_W-1:0] cfg_smp_per;
  logic [UPER_W-1:0] cfg_upd_per;
  logic [MINT_W-1:0] cfg_min_gap;
  logic [FRAC_W-1:0] cfg_frac;

  // Walk the ring for sum and max; average truncates, threshold adds the
  // truncated Q16 share of (max - average).
  function automatic void refresh_levels();
    int unsigned      total;
    int unsigned      top;
    logic [SMP_W-1:0] span;
    logic [PROD_W-1:0] share;
    total = 0;
    top = 0;
    for (int i = 0; i < DEPTH; i++) begin
      total += ring_mem[i];
      if (ring_mem[i] > top) top = ring_mem[i];
    end
    avg_lvl = SMP_W'(total / DEPTH);
    span = (top > avg_lvl) ? SMP_W'(top - avg_lvl) : '0;
    share = PROD_W'(span) * PROD_W'(cfg_frac);
    thr_lvl = SMP_W'(avg_lvl + share[PROD_W-1:FRAC_W]);
  endfunction

  function automatic beat_report_t detect_beat(input logic [TIME_W-1:0] now,
                                               input logic [SMP_W-1:0] smp);
    beat_report_t      rep;
    logic [TIME_W-1:0] since_smp;
    logic [TIME_W-1:0] since_upd;
    logic [TIME_W-1:0] since_beat;
    rep = '0;
    since_smp = now - t_last_smp;
    if (since_smp >= TIME_W'(cfg_smp_per)) begin
      rep.accepted = 1'b1;
      t_last_smp = now;
      ring_mem[ring_wr] = smp;
      ring_wr = (ring_wr + 1) % DEPTH;
      since_upd = now - t_last_upd;
      if (since_upd >= TIME_W'(cfg_upd_per)) begin
        t_last_upd = now;
        refresh_levels();
      end
      since_beat = now - t_last_beat;
      if (smp > thr_lvl && !peak_on && since_beat > TIME_W'(cfg_min_gap)) begin
        peak_on = 1'b1;
        t_last_beat = now;
        rep.beat = 1'b1;
      end else if (smp <= thr_lvl && peak_on) begin
        peak_on = 1'b0;
      end
    end
    rep.average_level  = avg_lvl;
    rep.beat_threshold = thr_lvl;
    rep.in_peak        = peak_on;
    return rep;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------
  beat_report_t pending_reports [$];  // expected results, oldest first
  req_tag_t     req_tags [$];         // one per request driven, not yet accepted
  int unsigned  faults;
  int unsigned  cycle_cnt;

  // Receiver pacing
  logic [7:0]   hold_ticket;  // bumped by the driver to request a long hold-off
  logic [7:0]   hold_seen;
  int unsigned  hold_left;
  int unsigned  rx_wait;
  int unsigned  rx_burst;

  // Driver pacing and waveform shaping
  int unsigned  tx_burst;
  int unsigned  pulse_pos;
  int unsigned  pulse_len;

  req_tag_t     mon_tag;
  beat_report_t mon_want;
  beat_report_t mon_seen;
  int unsigned  mon_draw;

  // Monitor, checker and receiver in one process: a request accepted at
  // an edge is predicted before any result at that edge is checked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_seen    <= '0;
      hold_left    <= 0;
      rx_wait      <= 0;
      rx_burst     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        mon_tag  = req_tags.pop_front();
        mon_want = detect_beat(in_if.now_ms, in_if.raw_sample);
        pending_reports.push_back(mon_tag.fixed ? mon_tag.rep : mon_want);
      end

      if (out_if.valid && out_if.ready) begin
        mon_seen = '{out_if.accepted, out_if.average_level, out_if.beat_threshold,
                     out_if.in_peak, out_if.beat};
        if (pending_reports.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result acc=%0d avg=%0d thr=%0d peak=%0d beat=%0d",
                     mon_seen.accepted, mon_seen.average_level, mon_seen.beat_threshold,
                     mon_seen.in_peak, mon_seen.beat);
        end else begin
          mon_want = pending_reports.pop_front();
          if (mon_seen.accepted !== mon_want.accepted ||
              mon_seen.average_level !== mon_want.average_level ||
              mon_seen.beat_threshold !== mon_want.beat_threshold ||
              mon_seen.in_peak !== mon_want.in_peak ||
              mon_seen.beat !== mon_want.beat) begin
            faults++;
            if (faults <= 10)
              $display("mismatch exp acc=%0d avg=%0d thr=%0d peak=%0d beat=%0d %s",
                       mon_want.accepted, mon_want.average_level, mon_want.beat_threshold,
                       mon_want.in_peak, mon_want.beat,
                       $sformatf("got acc=%0d avg=%0d thr=%0d peak=%0d beat=%0d",
                                 mon_seen.accepted, mon_seen.average_level,
                                 mon_seen.beat_threshold, mon_seen.in_peak,
                                 mon_seen.beat));
          end
        end
      end

      // ready: long hold-off on request, else a random wait after each result,
      // with occasional bursts of back-to-back acceptance
      if (hold_seen != hold_ticket) begin
        hold_seen    <= hold_ticket;
        hold_left    <= LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= (hold_left == 1);
      end else if (out_if.valid && out_if.ready) begin
        if (rx_burst != 0) begin
          rx_burst <= rx_burst - 1;
          mon_draw = 0;
        end else begin
          mon_draw = $urandom_range(0, 8);
          if ($urandom_range(0, 24) == 0) rx_burst <= $urandom_range(10, 30);
        end
        rx_wait      <= mon_draw;
        out_if.ready <= (mon_draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait      <= rx_wait - 1;
        out_if.ready <= (rx_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------

  // One sample request; returns at the edge it is accepted.
  task automatic send_req(input logic [TIME_W-1:0] now, input logic [SMP_W-1:0] smp,
                          input bit fixed, input beat_report_t rep);
    int unsigned gap;
    if (tx_burst != 0) begin
      tx_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 24) == 0) tx_burst = $urandom_range(10, 30);
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.now_ms     <= now;
    in_if.raw_sample <= smp;
    req_tags.push_back('{fixed, rep});
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result; with 'tail' also
  // let the slowest request work itself out before touching registers.
  task automatic settle(input bit tail);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    if (tail) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; the model follows each write.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] sper,
                              input logic [CFG_DATA_W-1:0] uper,
                              input logic [CFG_DATA_W-1:0] mint,
                              input logic [CFG_DATA_W-1:0] frac);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idxs [4];
    vals = '{sper, uper, mint, frac};
    idxs = '{CFG_SAMPLE_PERIOD, CFG_UPDATE_PERIOD, CFG_MIN_INTERVAL, CFG_THR_FRACTION};
    for (int k = 0; k < 4; k++) begin
      cfg_if.valid     <= 1'b1;
      cfg_if.reg_index <= idxs[k];
      cfg_if.wdata     <= vals[k];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      case (idxs[k])
        CFG_SAMPLE_PERIOD: cfg_smp_per = vals[k][SPER_W-1:0];
        CFG_UPDATE_PERIOD: cfg_upd_per = vals[k][UPER_W-1:0];
        CFG_MIN_INTERVAL:  cfg_min_gap = vals[k][MINT_W-1:0];
        CFG_THR_FRACTION:  cfg_frac    = vals[k][FRAC_W-1:0];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Pulse-like waveform: three high samples opening each pulse period over a low
  // baseline, with some full-range noise.
  function automatic logic [SMP_W-1:0] pulse_sample();
    logic [SMP_W-1:0] v;
    if ($urandom_range(0, 9) == 0)
      v = SMP_W'($urandom_range(0, 1023));
    else if (pulse_pos < 3)
      v = SMP_W'($urandom_range(650, 1023));
    else
      v = SMP_W'($urandom_range(80, 450));
    pulse_pos++;
    if (pulse_pos >= pulse_len) begin
      pulse_pos = 0;
      pulse_len = $urandom_range(6, 30);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    logic [TIME_W-1:0]     clk_ms;
    logic [CFG_DATA_W-1:0] sper, uper, mint, frac;
    int unsigned           per;
    int unsigned           pick;

    // known levels on reset, request and config inputs from time zero
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.now_ms     = '0;
    in_if.raw_sample = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wdata     = '0;
    hold_ticket      = '0;
    faults           = 0;
    tx_burst         = 0;
    pulse_pos        = 0;
    pulse_len        = 12;

    // model reset state
    foreach (ring_mem[i]) ring_mem[i] = '0;
    ring_wr     = 0;
    t_last_smp  = '0;
    t_last_upd  = '0;
    t_last_beat = '0;
    peak_on     = 1'b0;
    avg_lvl     = LEVEL_RST;
    thr_lvl     = LEVEL_RST;
    cfg_smp_per = SAMPLE_PERIOD_RST;
    cfg_upd_per = UPDATE_PERIOD_RST;
    cfg_min_gap = MIN_INTERVAL_RST;
    cfg_frac    = THR_FRACTION_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, at reset register values until the reconfig row
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].reconfig) begin
        settle(1'b1);
        program_regs(16'd0, 16'd0, 16'd0, 16'hFFFF);
      end
      send_req(DIRECTED_ROWS[r].now, DIRECTED_ROWS[r].smp,
               DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].rep);
    end
    clk_ms = 32'h8000_0001;

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle(1'b1);
      if (ph == NUM_PHASES - 1) begin
        sper = CFG_DATA_W'($urandom_range(0, 1023));
        uper = CFG_DATA_W'($urandom_range(0, 65535));
        mint = CFG_DATA_W'($urandom_range(0, 8191));
        frac = CFG_DATA_W'($urandom_range(0, 65535));
      end else begin
        sper = PHASES[ph].sper;
        uper = PHASES[ph].uper;
        mint = PHASES[ph].mint;
        frac = PHASES[ph].frac;
      end
      program_regs(sper, uper, mint, frac);
      per = (sper == 0) ? 1 : sper;

      for (int n = 0; n < PHASES[ph].count; n++) begin
        // receiver stalls for a long stretch while requests keep coming
        if (ph == 4 && n == 20) hold_ticket <= hold_ticket + 1;
        // sender goes quiet until the block has caught up
        if (ph == 0 && n == 110) settle(1'b0);

        pick = $urandom_range(0, 99);
        if (pick < 8)
          clk_ms += $urandom_range(0, per);         // mostly too early
        else if (pick < 11)
          clk_ms = $urandom;                        // arbitrary jump, wraps too
        else if (pick < 15)
          clk_ms += $urandom_range(0, 9000);        // long gap, may clear min interval
        else
          clk_ms += per + $urandom_range(0, per / 4 + 2);
        send_req(clk_ms, pulse_sample(), 1'b0, NO_REP);
      end
    end

    settle(1'b1);
    if (faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- pulse_beat_detector_top.f -----
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_channels.sv
hw/rtl/pbd_ctrl.sv
hw/rtl/pbd_datapath.sv
hw/rtl/pulse_beat_detector_top.sv
verif/pulse_beat_detector_top_tb.sv
